// ----- hw/rtl/actuator_transaction_guard_top_assert.svh -----
// Assertion macros for the actuator transaction guard checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ACTUATOR_TRANSACTION_GUARD_TOP_ASSERT_SVH
`define ACTUATOR_TRANSACTION_GUARD_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ATG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ATG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/atg_pkg.sv -----
// Types, codes and constants of the actuator transaction guard.
// No dependencies; used by atg_eval, the top level, the checker and the testbench.
package atg_pkg;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_ACK    = 2'd1,
		OP_CHECK  = 2'd2,
		OP_REINIT = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		MODE_IDLE         = 5'b00001,
		MODE_AWAIT_ACCEPT = 5'b00010,
		MODE_AWAIT_APPLY  = 5'b00100,
		MODE_APPLIED      = 5'b01000,
		MODE_FAULT        = 5'b10000
	} mode_t;

	localparam logic [2:0] GS_IDLE         = 3'd0;
	localparam logic [2:0] GS_AWAIT_ACCEPT = 3'd1;
	localparam logic [2:0] GS_AWAIT_APPLY  = 3'd2;
	localparam logic [2:0] GS_APPLIED      = 3'd3;
	localparam logic [2:0] GS_FAULT        = 3'd4;

	localparam logic [3:0] REASON_IDLE       = 4'd0;
	localparam logic [3:0] REASON_PENDING    = 4'd1;
	localparam logic [3:0] REASON_STALE      = 4'd2;
	localparam logic [3:0] REASON_AWAIT_ACC  = 4'd3;
	localparam logic [3:0] REASON_NONMATCH   = 4'd4;
	localparam logic [3:0] REASON_AWAIT_APP  = 4'd5;
	localparam logic [3:0] REASON_PHASE      = 4'd6;
	localparam logic [3:0] REASON_CONFIRMED  = 4'd7;
	localparam logic [3:0] REASON_EXPIRED    = 4'd8;

	localparam logic [1:0] FAULT_NONE     = 2'd0;
	localparam logic [1:0] FAULT_MISMATCH = 2'd1;
	localparam logic [1:0] FAULT_TIMEOUT  = 2'd2;

	localparam logic [1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [1:0] KIND_APPLIED  = 2'd1;

	localparam int FLAG_ACTIONABLE = 0;
	localparam int FLAG_BUS_OK     = 1;
	localparam int FLAG_CLAMPED    = 2;
	localparam int FLAG_AMBIGUOUS  = 3;

	localparam logic [31:0] WORD_ALL_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  flags;
		logic [31:0] request_seq;
		logic [31:0] decision_seq;
		logic [31:0] authorization_seq;
		logic [31:0] nonce_value;
		logic [15:0] requested_value;
		logic [31:0] deadline_time;
		logic [31:0] current_time;
		logic [1:0]  ack_kind;
		logic [15:0] accepted_value;
		logic [15:0] applied_value;
	} item_t;

	typedef struct packed {
		mode_t       mode;
		logic [3:0]  reason;
		logic [31:0] pend_rseq;
		logic [31:0] pend_dseq;
		logic [31:0] pend_aseq;
		logic [31:0] pend_nonce;
		logic [15:0] pend_code;
		logic [31:0] pend_deadline;
		logic [31:0] last_rseq;
		logic [31:0] last_aseq;
		logic [31:0] rejected;
		logic [1:0]  fault;
		logic        sticky;
	} guard_t;

	localparam guard_t GUARD_RESET = '{
		mode:          MODE_IDLE,
		reason:        REASON_IDLE,
		pend_rseq:     32'd0,
		pend_dseq:     32'd0,
		pend_aseq:     32'd0,
		pend_nonce:    32'd0,
		pend_code:     16'd0,
		pend_deadline: 32'd0,
		last_rseq:     32'd0,
		last_aseq:     32'd0,
		rejected:      32'd0,
		fault:         FAULT_NONE,
		sticky:        1'b0
	};

	function automatic logic [2:0] mode_code(mode_t m);
		logic [2:0] c;
		unique case (m)
			MODE_IDLE:         c = GS_IDLE;
			MODE_AWAIT_ACCEPT: c = GS_AWAIT_ACCEPT;
			MODE_AWAIT_APPLY:  c = GS_AWAIT_APPLY;
			MODE_APPLIED:      c = GS_APPLIED;
			MODE_FAULT:        c = GS_FAULT;
			default:           c = GS_FAULT;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/atg_eval.sv -----
// Next-state and ok decision of the guard for one item.
// Depends on atg_pkg.
module atg_eval (
	input  atg_pkg::item_t  item,
	input  atg_pkg::guard_t cur,
	output atg_pkg::guard_t nxt,
	output logic            ok
);

	function automatic atg_pkg::guard_t enter_fault(atg_pkg::guard_t s, logic [3:0] why,
			logic [1:0] code);
		atg_pkg::guard_t r;
		r = s;
		r.mode = atg_pkg::MODE_FAULT;
		r.reason = why;
		if (s.fault == atg_pkg::FAULT_NONE) begin
			r.fault = code;
		end
		r.sticky = 1'b1;
		return r;
	endfunction

	logic            echo_match;
	logic            start_bad;
	logic            awaiting;
	logic [31:0]     rej_inc;
	atg_pkg::guard_t rej_st;

	assign echo_match = (item.request_seq == cur.pend_rseq)
		&& (item.decision_seq == cur.pend_dseq)
		&& (item.authorization_seq == cur.pend_aseq)
		&& (item.nonce_value == cur.pend_nonce)
		&& (item.requested_value == cur.pend_code);

	assign start_bad = !item.flags[atg_pkg::FLAG_ACTIONABLE]
		|| (item.request_seq == 32'd0)
		|| (item.request_seq <= cur.last_rseq)
		|| (item.authorization_seq <= cur.last_aseq)
		|| (item.nonce_value == 32'd0)
		|| !(item.deadline_time > item.current_time);

	assign awaiting = (cur.mode == atg_pkg::MODE_AWAIT_ACCEPT)
		|| (cur.mode == atg_pkg::MODE_AWAIT_APPLY);

	// saturating rejection count
	assign rej_inc = (cur.rejected != atg_pkg::WORD_ALL_ONES) ? cur.rejected + 32'd1
		: cur.rejected;

	always_comb begin
		rej_st = cur;
		rej_st.rejected = rej_inc;
		nxt = cur;
		ok = 1'b0;
		case (item.op)
			atg_pkg::OP_START: begin
				if (cur.mode != atg_pkg::MODE_IDLE && cur.mode != atg_pkg::MODE_APPLIED) begin
					nxt = enter_fault(cur, atg_pkg::REASON_PENDING, atg_pkg::FAULT_MISMATCH);
				end else if (start_bad) begin
					nxt = enter_fault(cur, atg_pkg::REASON_STALE, atg_pkg::FAULT_MISMATCH);
				end else begin
					nxt.pend_rseq = item.request_seq;
					nxt.pend_dseq = item.decision_seq;
					nxt.pend_aseq = item.authorization_seq;
					nxt.pend_nonce = item.nonce_value;
					nxt.pend_code = item.requested_value;
					nxt.pend_deadline = item.deadline_time;
					nxt.last_rseq = item.request_seq;
					nxt.last_aseq = item.authorization_seq;
					nxt.mode = atg_pkg::MODE_AWAIT_ACCEPT;
					nxt.reason = atg_pkg::REASON_AWAIT_ACC;
					ok = 1'b1;
				end
			end
			atg_pkg::OP_ACK: begin
				if (!echo_match) begin
					nxt = enter_fault(rej_st, atg_pkg::REASON_NONMATCH,
						atg_pkg::FAULT_MISMATCH);
				end else if (cur.mode == atg_pkg::MODE_AWAIT_ACCEPT
						&& item.ack_kind == atg_pkg::KIND_ACCEPTED
						&& item.accepted_value == cur.pend_code) begin
					nxt.mode = atg_pkg::MODE_AWAIT_APPLY;
					nxt.reason = atg_pkg::REASON_AWAIT_APP;
					ok = 1'b1;
				end else if (cur.mode == atg_pkg::MODE_AWAIT_APPLY
						&& item.ack_kind == atg_pkg::KIND_APPLIED
						&& item.flags[atg_pkg::FLAG_BUS_OK]
						&& !item.flags[atg_pkg::FLAG_CLAMPED]
						&& !item.flags[atg_pkg::FLAG_AMBIGUOUS]
						&& item.accepted_value == cur.pend_code
						&& item.applied_value == cur.pend_code) begin
					nxt.mode = atg_pkg::MODE_APPLIED;
					nxt.reason = atg_pkg::REASON_CONFIRMED;
					ok = 1'b1;
				end else begin
					nxt = enter_fault(rej_st, atg_pkg::REASON_PHASE, atg_pkg::FAULT_MISMATCH);
				end
			end
			atg_pkg::OP_CHECK: begin
				if (awaiting && (item.current_time >= cur.pend_deadline)) begin
					nxt = enter_fault(cur, atg_pkg::REASON_EXPIRED, atg_pkg::FAULT_TIMEOUT);
				end else begin
					ok = (cur.mode != atg_pkg::MODE_FAULT);
				end
			end
			default: begin
				// reinitialize: the fault latch and fail-static flag survive
				nxt = atg_pkg::GUARD_RESET;
				nxt.fault = cur.fault;
				nxt.sticky = cur.sticky;
				ok = 1'b1;
			end
		endcase
	end

endmodule

// ----- hw/rtl/actuator_transaction_guard_top.sv -----
// Top level of the actuator transaction guard: input register, guard state, result register.
// Depends on atg_pkg and atg_eval.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_stall | op, flags, sequences, nonce, codes, times
//  result   | out_valid/out_stall | ok, guard_state, reason_code, counters
//
// One item per cycle sustained while the result is not stalled; an accepted item
// waits in the input register, then moves into the result register and leaves
// from there. The guard state updates as the item leaves the input register, so
// the next item already sees it. Reset (arst_n low) empties both registers and
// returns the guard to idle with no latched fault. A stalled result holds; the input
// register keeps accepting as long as its item can move on, otherwise in_stall is raised.
module actuator_transaction_guard_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [3:0]  flags,
	input  logic [31:0] request_seq,
	input  logic [31:0] decision_seq,
	input  logic [31:0] authorization_seq,
	input  logic [31:0] nonce_value,
	input  logic [15:0] requested_value,
	input  logic [31:0] deadline_time,
	input  logic [31:0] current_time,
	input  logic [1:0]  ack_kind,
	input  logic [15:0] accepted_value,
	input  logic [15:0] applied_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [2:0]  guard_state,
	output logic [3:0]  reason_code,
	output logic [31:0] rejected_count,
	output logic [1:0]  latched_fault_code,
	output logic        fail_static_flag
);

	// input register
	logic            valid_s1;
	atg_pkg::item_t  item_s1;

	// guard state
	atg_pkg::guard_t guard_q;
	atg_pkg::guard_t guard_nxt;
	logic            ok_nxt;

	// result register
	logic            valid_s2;
	logic            ok_s2;
	logic [2:0]      state_s2;
	logic [3:0]      reason_s2;
	logic [31:0]     rej_s2;
	logic [1:0]      fault_s2;
	logic            fail_s2;

	logic            adv_s1;
	logic            take_in;

	// s1 moves on when the result slot is free or being emptied
	assign adv_s1  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{
				op:                op,
				flags:             flags,
				request_seq:       request_seq,
				decision_seq:      decision_seq,
				authorization_seq: authorization_seq,
				nonce_value:       nonce_value,
				requested_value:   requested_value,
				deadline_time:     deadline_time,
				current_time:      current_time,
				ack_kind:          ack_kind,
				accepted_value:    accepted_value,
				applied_value:     applied_value
			};
		end
	end

	atg_eval u_eval (
		.item (item_s1),
		.cur  (guard_q),
		.nxt  (guard_nxt),
		.ok   (ok_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q <= atg_pkg::GUARD_RESET;
		end else if (adv_s1) begin
			guard_q <= guard_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// result is the guard as the item leaves it
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ok_s2     <= ok_nxt;
			state_s2  <= atg_pkg::mode_code(guard_nxt.mode);
			reason_s2 <= guard_nxt.reason;
			rej_s2    <= guard_nxt.rejected;
			fault_s2  <= guard_nxt.fault;
			fail_s2   <= guard_nxt.sticky;
		end
	end

	assign out_valid          = valid_s2;
	assign ok                 = ok_s2;
	assign guard_state        = state_s2;
	assign reason_code        = reason_s2;
	assign rejected_count     = rej_s2;
	assign latched_fault_code = fault_s2;
	assign fail_static_flag   = fail_s2;

endmodule

// ----- hw/rtl/atg_checker.sv -----
// Port-level checks of the actuator transaction guard, bound to the top level.
// Depends on atg_pkg and actuator_transaction_guard_top_assert.svh.
`include "actuator_transaction_guard_top_assert.svh"

module atg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        ok,
	input logic [2:0]  guard_state,
	input logic [3:0]  reason_code,
	input logic [31:0] rejected_count,
	input logic [1:0]  latched_fault_code,
	input logic        fail_static_flag
);

	logic        held;
	logic [42:0] res;
	logic        is_fault;
	logic        is_applied;
	logic        has_fault;
	logic        confirmed;

	assign held = out_valid && out_stall;
	assign res = {ok, guard_state, reason_code, rejected_count, latched_fault_code,
		fail_static_flag};
	assign is_fault = (guard_state == atg_pkg::GS_FAULT);
	assign is_applied = (guard_state == atg_pkg::GS_APPLIED);
	assign has_fault = (latched_fault_code != atg_pkg::FAULT_NONE);
	assign confirmed = (reason_code == atg_pkg::REASON_CONFIRMED);

	// a stalled result stays put
	`ATG_ASSERT_NEXT(a_hold, clk, arst_n, held, out_valid && $stable(res), "stalled result moved")

	// a good outcome never leaves the guard in fault
	`ATG_ASSERT_NOW(a_ok_not_fault, clk, arst_n, out_valid && ok, !is_fault, "ok while in fault")

	// fail-static is only set together with a latched fault
	`ATG_ASSERT_NOW(a_sticky, clk, arst_n, out_valid && fail_static_flag, has_fault, "flag, no fault")

	// the confirmed reason only goes with the applied state
	`ATG_ASSERT_NOW(a_confirmed, clk, arst_n, out_valid && confirmed, is_applied, "confirmed, not applied")

endmodule

bind actuator_transaction_guard_top atg_checker u_atg_checker (.*);

// ----- sim/actuator_transaction_guard_top_test.sv -----
// Self-checking testbench for actuator_transaction_guard_top: drives guard commands and
// acknowledgements, predicts each verdict and compares it with the result channel.
// Depends on atg_pkg and the RTL of the top level.
module actuator_transaction_guard_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	// run shape
	localparam int ITEM_TARGET    = 1750;
	localparam int TAIL_ITEMS     = 200;   // last stretch runs with no idling at all
	localparam int HOLD_CYCLES    = 150;   // long receiver hold-off, fills the pipe
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
	localparam int DRAIN_CYCLES   = 8;     // margin after the drain to catch stray results

	// sequences near the top of the range force a reinit before the next transaction
	localparam logic [31:0] LAST_CEILING = 32'hFFFF_FF00;

	localparam logic [1:0] KIND_NEITHER    = 2'd3;
	localparam logic [3:0] ACTIONABLE_ONLY = 4'(1) << atg_pkg::FLAG_ACTIONABLE;
	localparam logic [3:0] BUS_OK_ONLY     = 4'(1) << atg_pkg::FLAG_BUS_OK;

	// ways a transaction is broken on purpose
	typedef enum int {
		FLAW_NONE,
		FLAW_EXPIRE,
		FLAW_ECHO,
		FLAW_KIND,
		FLAW_ACCEPT_VALUE,
		FLAW_APPLY_FLAGS,
		FLAW_APPLY_VALUE,
		FLAW_RESTART,
		FLAW_BAD_START,
		FLAW_LATE_ACK
	} flaw_t;

	// one result item as seen on the output ports
	typedef struct packed {
		logic        ok;
		logic [2:0]  guard_state;
		logic [3:0]  reason;
		logic [31:0] rejected;
		logic [1:0]  fault;
		logic        sticky;
	} verdict_t;

	// Shadow copy of the guard plus the verdicts still owed by the block.
	class guard_shadow;
		logic [2:0]  mode;
		logic [3:0]  reason;
		logic [31:0] pend_rseq, pend_dseq, pend_aseq, pend_nonce, pend_deadline;
		logic [15:0] pend_code;
		logic [31:0] last_rseq, last_aseq, rejected;
		logic [1:0]  fault;
		logic        sticky;
		verdict_t    due_verdicts[$];
		int          miscompares;

		function new();
			clear_guard();
			fault = atg_pkg::FAULT_NONE;
			sticky = 1'b0;
			miscompares = 0;
		endfunction

		// reinit clears everything except the fault latch and fail-static flag
		function void clear_guard();
			mode = atg_pkg::GS_IDLE;
			reason = atg_pkg::REASON_IDLE;
			pend_rseq = '0;
			pend_dseq = '0;
			pend_aseq = '0;
			pend_nonce = '0;
			pend_code = '0;
			pend_deadline = '0;
			last_rseq = '0;
			last_aseq = '0;
			rejected = '0;
		endfunction

		// first nonzero fault wins, fail-static set on every fault
		function void trip(logic [3:0] why, logic [1:0] kind_of_fault);
			mode = atg_pkg::GS_FAULT;
			reason = why;
			if (fault == atg_pkg::FAULT_NONE)
				fault = kind_of_fault;
			sticky = 1'b1;
		endfunction

		function void bump_rejected();
			if (rejected != atg_pkg::WORD_ALL_ONES)
				rejected++;
		endfunction

		function void take_item(atg_pkg::item_t it);
			verdict_t v;
			logic     echo_hit;
			v = '0;
			case (it.op)
				atg_pkg::OP_START: begin
					if (mode != atg_pkg::GS_IDLE && mode != atg_pkg::GS_APPLIED) begin
						trip(atg_pkg::REASON_PENDING, atg_pkg::FAULT_MISMATCH);
					end else if (!it.flags[atg_pkg::FLAG_ACTIONABLE] || it.request_seq == 0 ||
							it.request_seq <= last_rseq ||
							it.authorization_seq <= last_aseq ||
							it.nonce_value == 0 ||
							!(it.deadline_time > it.current_time)) begin
						trip(atg_pkg::REASON_STALE, atg_pkg::FAULT_MISMATCH);
					end else begin
						pend_rseq = it.request_seq;
						pend_dseq = it.decision_seq;
						pend_aseq = it.authorization_seq;
						pend_nonce = it.nonce_value;
						pend_code = it.requested_value;
						pend_deadline = it.deadline_time;
						last_rseq = it.request_seq;
						last_aseq = it.authorization_seq;
						mode = atg_pkg::GS_AWAIT_ACCEPT;
						reason = atg_pkg::REASON_AWAIT_ACC;
						v.ok = 1'b1;
					end
				end
				atg_pkg::OP_ACK: begin
					// pending fields are zero after reset or reinit, so a zero echo matches
					echo_hit = it.request_seq == pend_rseq && it.decision_seq == pend_dseq &&
						it.authorization_seq == pend_aseq && it.nonce_value == pend_nonce &&
						it.requested_value == pend_code;
					if (!echo_hit) begin
						bump_rejected();
						trip(atg_pkg::REASON_NONMATCH, atg_pkg::FAULT_MISMATCH);
					end else if (mode == atg_pkg::GS_AWAIT_ACCEPT &&
							it.ack_kind == atg_pkg::KIND_ACCEPTED &&
							it.accepted_value == pend_code) begin
						mode = atg_pkg::GS_AWAIT_APPLY;
						reason = atg_pkg::REASON_AWAIT_APP;
						v.ok = 1'b1;
					end else if (mode == atg_pkg::GS_AWAIT_APPLY &&
							it.ack_kind == atg_pkg::KIND_APPLIED &&
							it.flags[atg_pkg::FLAG_BUS_OK] &&
							!it.flags[atg_pkg::FLAG_CLAMPED] &&
							!it.flags[atg_pkg::FLAG_AMBIGUOUS] &&
							it.accepted_value == pend_code &&
							it.applied_value == pend_code) begin
						mode = atg_pkg::GS_APPLIED;
						reason = atg_pkg::REASON_CONFIRMED;
						v.ok = 1'b1;
					end else begin
						bump_rejected();
						trip(atg_pkg::REASON_PHASE, atg_pkg::FAULT_MISMATCH);
					end
				end
				atg_pkg::OP_CHECK: begin
					// expiry is a plain unsigned compare, only in the awaiting states
					if ((mode == atg_pkg::GS_AWAIT_ACCEPT || mode == atg_pkg::GS_AWAIT_APPLY) &&
							it.current_time >= pend_deadline)
						trip(atg_pkg::REASON_EXPIRED, atg_pkg::FAULT_TIMEOUT);
					else
						v.ok = (mode != atg_pkg::GS_FAULT);
				end
				atg_pkg::OP_REINIT: begin
					clear_guard();
					v.ok = 1'b1;
				end
			endcase
			v.guard_state = mode;
			v.reason = reason;
			v.rejected = rejected;
			v.fault = fault;
			v.sticky = sticky;
			due_verdicts.push_back(v);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
				miscompares++;
			end
		endfunction

		function void match_verdict(verdict_t got);
			verdict_t want;
			if (due_verdicts.size() == 0) begin
				$display("%0t: result expected none, got ok=%0d state=%0d reason=%0d",
					$time, got.ok, got.guard_state, got.reason);
				miscompares++;
				return;
			end
			want = due_verdicts.pop_front();
			compare_field("ok", want.ok, got.ok);
			compare_field("guard_state", want.guard_state, got.guard_state);
			compare_field("reason_code", want.reason, got.reason);
			compare_field("rejected_count", want.rejected, got.rejected);
			compare_field("latched_fault_code", want.fault, got.fault);
			compare_field("fail_static_flag", want.sticky, got.sticky);
		endfunction
	endclass

	// ports; every input starts at a known value
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = '0;
	logic [3:0]  flags = '0;
	logic [31:0] request_seq = '0;
	logic [31:0] decision_seq = '0;
	logic [31:0] authorization_seq = '0;
	logic [31:0] nonce_value = '0;
	logic [15:0] requested_value = '0;
	logic [31:0] deadline_time = '0;
	logic [31:0] current_time = '0;
	logic [1:0]  ack_kind = '0;
	logic [15:0] accepted_value = '0;
	logic [15:0] applied_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        ok;
	logic [2:0]  guard_state;
	logic [3:0]  reason_code;
	logic [31:0] rejected_count;
	logic [1:0]  latched_fault_code;
	logic        fail_static_flag;

	guard_shadow book;

	// stimulus bookkeeping
	atg_pkg::item_t txn;                  // last start sent, source of the echoes
	logic [31:0] gen_last_r = '0;         // generator's idea of the last taken sequences
	logic [31:0] gen_last_a = '0;
	bit          dirty = 1'b0;            // guard may be off the clean path, reinit first
	bit          gaps_on = 1'b1;          // sender idling allowed
	bit          tail = 1'b0;             // final stretch, nobody idles
	bit          hold_req = 1'b0;         // ask the receiver for the long hold-off
	int          sent = 0;

	actuator_transaction_guard_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.flags(flags),
		.request_seq(request_seq),
		.decision_seq(decision_seq),
		.authorization_seq(authorization_seq),
		.nonce_value(nonce_value),
		.requested_value(requested_value),
		.deadline_time(deadline_time),
		.current_time(current_time),
		.ack_kind(ack_kind),
		.accepted_value(accepted_value),
		.applied_value(applied_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.guard_state(guard_state),
		.reason_code(reason_code),
		.rejected_count(rejected_count),
		.latched_fault_code(latched_fault_code),
		.fail_static_flag(fail_static_flag)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both channels are sampled right after the edge, before any NBA lands, so the
	// values seen are the ones the block saw at that edge.
	always @(posedge clk) begin : monitor
		atg_pkg::item_t seen;
		verdict_t       got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				seen = {op, flags, request_seq, decision_seq, authorization_seq, nonce_value,
					requested_value, deadline_time, current_time, ack_kind,
					accepted_value, applied_value};
				book.take_item(seen);
			end
			if (out_valid && !out_stall) begin
				got = {ok, guard_state, reason_code, rejected_count, latched_fault_code,
					fail_static_flag};
				book.match_verdict(got);
			end
		end
	end

	// Hang detection: no handshake on either side for too long ends the run.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	// Receiver: random stall bursts, quiet stretches, and one long hold-off on request.
	// Each stalling branch makes its first assignment, then lets time pass before the next one.
	initial begin : receiver
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (!tail && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				repeat ($urandom_range(0, 24)) @(posedge clk);
			end
		end
	end

	function automatic atg_pkg::item_t random_item();
		atg_pkg::item_t it;
		it.op = 2'($urandom);
		it.flags = 4'($urandom);
		it.request_seq = $urandom;
		it.decision_seq = $urandom;
		it.authorization_seq = $urandom;
		it.nonce_value = $urandom;
		it.requested_value = 16'($urandom);
		it.deadline_time = $urandom;
		it.current_time = $urandom;
		it.ack_kind = 2'($urandom);
		it.accepted_value = 16'($urandom);
		it.applied_value = 16'($urandom);
		return it;
	endfunction

	// acknowledgement that echoes the last start exactly; the rest is random
	function automatic atg_pkg::item_t echo_item();
		atg_pkg::item_t it;
		it = random_item();
		it.op = atg_pkg::OP_ACK;
		it.request_seq = txn.request_seq;
		it.decision_seq = txn.decision_seq;
		it.authorization_seq = txn.authorization_seq;
		it.nonce_value = txn.nonce_value;
		it.requested_value = txn.requested_value;
		return it;
	endfunction

	// flip one bit of one echoed field
	function automatic atg_pkg::item_t garble_echo(atg_pkg::item_t it);
		case ($urandom_range(0, 4))
			0: it.request_seq ^= 32'd1 << $urandom_range(0, 31);
			1: it.decision_seq ^= 32'd1 << $urandom_range(0, 31);
			2: it.authorization_seq ^= 32'd1 << $urandom_range(0, 31);
			3: it.nonce_value ^= 32'd1 << $urandom_range(0, 31);
			default: it.requested_value ^= 16'd1 << $urandom_range(0, 15);
		endcase
		return it;
	endfunction

	// mostly small steps, now and then a leap toward the top of the range
	function automatic logic [31:0] next_above(logic [31:0] last);
		if ($urandom_range(0, 7) == 0)
			return last + $urandom_range(1, atg_pkg::WORD_ALL_ONES - last);
		return last + $urandom_range(1, 64);
	endfunction

	// Present one item and hold it until the block takes it. Returns in the time step
	// of the accepting edge, so a following call keeps in_valid high without a dip.
	task automatic offer(input atg_pkg::item_t it);
		if (gaps_on && !hold_req && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		op <= it.op;
		flags <= it.flags;
		request_seq <= it.request_seq;
		decision_seq <= it.decision_seq;
		authorization_seq <= it.authorization_seq;
		nonce_value <= it.nonce_value;
		requested_value <= it.requested_value;
		deadline_time <= it.deadline_time;
		current_time <= it.current_time;
		ack_kind <= it.ack_kind;
		accepted_value <= it.accepted_value;
		applied_value <= it.applied_value;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_reinit();
		atg_pkg::item_t it;
		it = random_item();
		it.op = atg_pkg::OP_REINIT;
		offer(it);
	endtask

	task automatic send_check(input logic [31:0] now);
		atg_pkg::item_t it;
		it = random_item();
		it.op = atg_pkg::OP_CHECK;
		it.current_time = now;
		offer(it);
	endtask

	task automatic send_start(input logic [31:0] rseq, dseq, aseq, nonce,
			input logic [15:0] code, input logic [31:0] deadline, now,
			input logic [3:0] fl);
		atg_pkg::item_t it;
		it = random_item();
		it.op = atg_pkg::OP_START;
		it.flags = fl;
		it.request_seq = rseq;
		it.decision_seq = dseq;
		it.authorization_seq = aseq;
		it.nonce_value = nonce;
		it.requested_value = code;
		it.deadline_time = deadline;
		it.current_time = now;
		txn = it;
		offer(it);
	endtask

	task automatic send_ack(input logic [1:0] kind, input logic [3:0] fl,
			input logic [15:0] accv, appv);
		atg_pkg::item_t it;
		it = echo_item();
		it.ack_kind = kind;
		it.flags = fl;
		it.accepted_value = accv;
		it.applied_value = appv;
		offer(it);
	endtask

	// Directed corner cases. The first fault is a timeout so that the first-wins
	// latch is seen holding a timeout against later mismatches.
	task automatic run_directed();
		atg_pkg::item_t it;
		send_reinit();                                          // reinit while idle
		send_check(32'd0);                                      // check outside awaiting
		send_start(32'd1, 32'd0, 32'd1, 32'd1, 16'd0, 32'd1, 32'd0, ACTIONABLE_ONLY);
		send_check(32'd0);                                      // now below deadline: not yet expired
		send_check(32'd1);                                      // now == deadline: expired
		send_check(atg_pkg::WORD_ALL_ONES);                     // check while faulted
		send_start(32'd2, 32'd0, 32'd2, 32'd2, 16'd0, 32'd9, 32'd0, ACTIONABLE_ONLY);
		it = echo_item();                                       // echo off by request seq
		it.request_seq = '0;
		offer(it);
		send_reinit();                                          // counter clears, latch stays
		it = random_item();                                     // all-zero echo from idle
		it.op = atg_pkg::OP_ACK;
		it.request_seq = '0;
		it.decision_seq = '0;
		it.authorization_seq = '0;
		it.nonce_value = '0;
		it.requested_value = '0;
		it.ack_kind = atg_pkg::KIND_ACCEPTED;
		it.accepted_value = '0;
		offer(it);
		send_reinit();
		// everything at the top of its range, but now sits just below the deadline
		send_start(atg_pkg::WORD_ALL_ONES, atg_pkg::WORD_ALL_ONES, atg_pkg::WORD_ALL_ONES,
			atg_pkg::WORD_ALL_ONES, 16'hFFFF, atg_pkg::WORD_ALL_ONES,
			atg_pkg::WORD_ALL_ONES - 1, 4'hF);
		send_ack(atg_pkg::KIND_ACCEPTED, 4'h0, 16'hFFFF, 16'h0000);
		send_ack(atg_pkg::KIND_APPLIED, BUS_OK_ONLY, 16'hFFFF, 16'hFFFF);
		// from applied, same sequences again are stale
		send_start(atg_pkg::WORD_ALL_ONES, 32'd0, atg_pkg::WORD_ALL_ONES, 32'd7, 16'd1,
			32'd9, 32'd0, ACTIONABLE_ONLY);
		send_reinit();
		send_start(32'd3, 32'd0, 32'd3, 32'd0, 16'd1, 32'd9, 32'd0, ACTIONABLE_ONLY);
		send_reinit();
		send_start(32'd3, 32'd0, 32'd3, 32'd3, 16'd1, 32'd9, 32'd0, ~ACTIONABLE_ONLY);
		send_reinit();
		send_start(32'd5, 32'd0, 32'd5, 32'd5, 16'd1, 32'd7, 32'd7, ACTIONABLE_ONLY);
		send_reinit();
		send_start(32'd1, 32'd0, 32'd1, 32'd1, 16'h1234, 32'd100, 32'd50, ACTIONABLE_ONLY);
		send_ack(KIND_NEITHER, 4'h0, 16'h1234, 16'h1234);      // kind matches no phase
		send_reinit();
	endtask

	// One command through its phases, clean or with a single injected flaw.
	task automatic run_transaction();
		flaw_t          flaw;
		bit             late;
		logic [31:0]    now, deadline, limit;
		atg_pkg::item_t it;
		flaw = FLAW_NONE;
		late = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0)
			flaw = flaw_t'($urandom_range(FLAW_EXPIRE, FLAW_LATE_ACK));
		if (dirty || gen_last_r > LAST_CEILING || gen_last_a > LAST_CEILING ||
				$urandom_range(0, 5) == 0) begin
			send_reinit();
			gen_last_r = '0;
			gen_last_a = '0;
			dirty = 1'b0;
		end

		// start: deadline sometimes just past now to hit the expiry boundary
		now = $urandom_range(0, atg_pkg::WORD_ALL_ONES - 1);
		limit = atg_pkg::WORD_ALL_ONES - now;
		if ($urandom_range(0, 1) == 0 && limit > 4)
			limit = 4;
		deadline = now + $urandom_range(1, limit);
		it = random_item();
		it.op = atg_pkg::OP_START;
		it.flags[atg_pkg::FLAG_ACTIONABLE] = 1'b1;
		it.request_seq = next_above(gen_last_r);
		it.authorization_seq = next_above(gen_last_a);
		it.nonce_value = $urandom_range(1, atg_pkg::WORD_ALL_ONES);
		it.deadline_time = deadline;
		it.current_time = now;
		if (flaw == FLAW_BAD_START) begin
			case ($urandom_range(0, 4))
				0: it.flags[atg_pkg::FLAG_ACTIONABLE] = 1'b0;
				1: it.request_seq = $urandom_range(0, gen_last_r);
				2: it.authorization_seq = $urandom_range(0, gen_last_a);
				3: it.nonce_value = '0;
				default: it.deadline_time = $urandom_range(0, now);
			endcase
			offer(it);
			dirty = 1'b1;
			return;
		end
		txn = it;
		offer(it);
		gen_last_r = it.request_seq;
		gen_last_a = it.authorization_seq;
		if (flaw == FLAW_RESTART) begin
			it = random_item();
			it.op = atg_pkg::OP_START;
			offer(it);
			dirty = 1'b1;
			return;
		end

		// awaiting acceptance
		if (flaw == FLAW_EXPIRE && !late) begin
			send_check($urandom_range(deadline, atg_pkg::WORD_ALL_ONES));
			dirty = 1'b1;
			return;
		end
		if ($urandom_range(0, 2) == 0)
			send_check($urandom_range(0, deadline - 1));
		it = echo_item();
		it.ack_kind = atg_pkg::KIND_ACCEPTED;
		it.accepted_value = txn.requested_value;
		if (flaw == FLAW_ECHO && !late)
			it = garble_echo(it);
		if (flaw == FLAW_KIND)
			it.ack_kind = 2'($urandom_range(1, 3));
		if (flaw == FLAW_ACCEPT_VALUE)
			it.accepted_value ^= 16'($urandom_range(1, 16'hFFFF));
		offer(it);
		if ((flaw == FLAW_ECHO && !late) || flaw == FLAW_KIND || flaw == FLAW_ACCEPT_VALUE) begin
			dirty = 1'b1;
			return;
		end

		// awaiting application
		if (flaw == FLAW_EXPIRE) begin
			send_check($urandom_range(deadline, atg_pkg::WORD_ALL_ONES));
			dirty = 1'b1;
			return;
		end
		if ($urandom_range(0, 2) == 0)
			send_check($urandom_range(0, deadline - 1));
		it = echo_item();
		it.ack_kind = atg_pkg::KIND_APPLIED;
		it.flags[atg_pkg::FLAG_BUS_OK] = 1'b1;
		it.flags[atg_pkg::FLAG_CLAMPED] = 1'b0;
		it.flags[atg_pkg::FLAG_AMBIGUOUS] = 1'b0;
		it.accepted_value = txn.requested_value;
		it.applied_value = txn.requested_value;
		if (flaw == FLAW_ECHO)
			it = garble_echo(it);
		if (flaw == FLAW_APPLY_FLAGS) begin
			case ($urandom_range(0, 2))
				0: it.flags[atg_pkg::FLAG_BUS_OK] = 1'b0;
				1: it.flags[atg_pkg::FLAG_CLAMPED] = 1'b1;
				default: it.flags[atg_pkg::FLAG_AMBIGUOUS] = 1'b1;
			endcase
		end
		if (flaw == FLAW_APPLY_VALUE) begin
			if ($urandom_range(0, 1) == 0)
				it.accepted_value ^= 16'($urandom_range(1, 16'hFFFF));
			else
				it.applied_value ^= 16'($urandom_range(1, 16'hFFFF));
		end
		offer(it);
		if (flaw == FLAW_ECHO || flaw == FLAW_APPLY_FLAGS || flaw == FLAW_APPLY_VALUE) begin
			dirty = 1'b1;
			return;
		end

		// applied: a further matching acknowledgement is out of phase
		if (flaw == FLAW_LATE_ACK) begin
			offer(echo_item());
			dirty = 1'b1;
			return;
		end
		if ($urandom_range(0, 3) == 0)
			send_check($urandom);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 3))
			offer(random_item());
		dirty = 1'b1;
	endtask

	initial begin : stimulus
		book = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// long receiver hold-off while the sender keeps offering back to back
		hold_req = 1'b1;
		repeat (10)
			run_transaction();

		while (sent < ITEM_TARGET) begin
			if (sent > ITEM_TARGET - TAIL_ITEMS) begin
				tail = 1'b1;
				gaps_on = 1'b0;
			end else begin
				gaps_on = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 4) == 0)
				send_noise();
			else
				run_transaction();
		end
		in_valid <= 1'b0;

		// drain, then wait out DRAIN_CYCLES to catch anything extra
		while (book.due_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.miscompares == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/atg_pkg.sv
hw/rtl/atg_eval.sv
hw/rtl/actuator_transaction_guard_top.sv
hw/rtl/atg_checker.sv
sim/actuator_transaction_guard_top_test.sv
